// ----- rtl/brick_request_table_core_macros.svh -----
// Assertion macros shared by the brick request table RTL.
// Every use expects clk and rst_n in scope; no other dependencies.
`ifndef BRICK_REQUEST_TABLE_CORE_MACROS_SVH
`define BRICK_REQUEST_TABLE_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset
`define BRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define BRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/brt_pkg.sv -----
// Shared types, widths and codes for the brick request table.
// No dependencies; used by every other RTL file but the macro header.
package brt_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int DIM_W   = 16;
  localparam int CMD_W   = 3;
  localparam int KEY_W   = 32;
  localparam int ENTRY_W = 64;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 11;
  localparam int CFG_IDX_W = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Command codes
  localparam cmd_t CMD_CLEAR  = 3'd0;
  localparam cmd_t CMD_APPEND = 3'd1;
  localparam cmd_t CMD_FIND   = 3'd2;
  localparam cmd_t CMD_REMOVE = 3'd3;
  localparam cmd_t CMD_VERIFY = 3'd4;

  // Result status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_BAD     = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t CFG_DIM0 = 2'd0;
  localparam cfg_idx_t CFG_DIM1 = 2'd1;
  localparam cfg_idx_t CFG_DIM2 = 2'd2;
  localparam cfg_idx_t CFG_DIM3 = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SCAN,
    S_FINISH
  } state_t;

  // Per-command scan setup: dimensions, partial strides and the key sought
  typedef struct packed {
    logic [DIM_W-1:0] dim3;
    logic [DIM_W-1:0] dim2;
    logic [DIM_W-1:0] dim1;
    logic [DIM_W-1:0] dim0;
    logic [KEY_W-1:0] m2;
    logic [KEY_W-1:0] m3;
    logic [KEY_W-1:0] key;
  } scan_cfg_t;

  // One entry leaving the key pipeline
  typedef struct packed {
    logic               valid;
    logic               match;
    logic               bad;
    logic [ENTRY_W-1:0] entry;
  } scan_res_t;

endpackage

// ----- rtl/brt_if.sv -----
// Valid/ready channel interfaces for the command items and result items.
// Depends on brt_pkg for field widths.
interface brt_in_if;
  logic                            valid;
  logic                            ready;
  logic [brt_pkg::CMD_W-1:0]       command;
  logic [brt_pkg::DIM_W-1:0]       coord_0;
  logic [brt_pkg::DIM_W-1:0]       coord_1;
  logic [brt_pkg::DIM_W-1:0]       coord_2;
  logic [brt_pkg::DIM_W-1:0]       coord_3;
  logic [brt_pkg::KEY_W-1:0]       search_key;

  modport source (output valid, command, coord_0, coord_1, coord_2, coord_3, search_key,
                  input ready);
  modport sink   (input valid, command, coord_0, coord_1, coord_2, coord_3, search_key,
                  output ready);
endinterface

interface brt_out_if;
  logic                            valid;
  logic                            ready;
  logic [brt_pkg::STAT_W-1:0]      status;
  logic [brt_pkg::OUT_W-1:0]       entry_total;
  logic [brt_pkg::OUT_W-1:0]       position;

  modport source (output valid, status, entry_total, position, input ready);
  modport sink   (input valid, status, entry_total, position, output ready);
endinterface

// ----- rtl/brick_request_table_core.sv -----
// Brick request table: ordered table of 4-D brick coordinates with five commands.
// Depends on brt_pkg, brt_if, brt_entry_mem, brt_key_pipe and brt_ctrl.
//
// Usage:
//   in_chan carries one command item (command, coord_0..3, search_key); out_chan
//   returns exactly one result item (status, entry_total, position) per command.
//   cfg_we/cfg_index/cfg_wdata write the four dimension registers; write them
//   only while no command is in flight.
// Sequencing:
//   Clear, append and unused codes go from acceptance straight to S_FINISH.
//   Find, remove and verify pass S_MUL1 and S_MUL2, which form the stride
//   products, then the single read port of the entry memory is swept one entry
//   a cycle and the key pipeline (stage one, stage two) drains. One command is
//   worked on at a time; the next is accepted once the current result is in
//   the output register, even while that result waits.
// Reset:
//   rst_n empties the table and sets every dimension register to 1. The entry
//   memory is not cleared; only entries below the count are ever read.
// Stalls:
//   While out_chan.ready is low the result holds and a finished command waits
//   for the output register before loading it.
module brick_request_table_core #(
  parameter int TABLE_DEPTH = brt_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  brt_in_if.sink                        in_chan,
  brt_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [brt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brt_pkg::DIM_W-1:0]     cfg_wdata
);

  logic [brt_pkg::DIM_W-1:0]   dim0_r, dim1_r, dim2_r, dim3_r;
  logic                        mem_we, mem_re;
  logic [IDX_W-1:0]            mem_waddr, mem_raddr;
  logic [brt_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;
  brt_pkg::scan_cfg_t          scfg;
  brt_pkg::scan_res_t          res;

  // Dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim0_r <= brt_pkg::DIM_W'(1);
      dim1_r <= brt_pkg::DIM_W'(1);
      dim2_r <= brt_pkg::DIM_W'(1);
      dim3_r <= brt_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        brt_pkg::CFG_DIM0: dim0_r <= cfg_wdata;
        brt_pkg::CFG_DIM1: dim1_r <= cfg_wdata;
        brt_pkg::CFG_DIM2: dim2_r <= cfg_wdata;
        brt_pkg::CFG_DIM3: dim3_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  brt_entry_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  brt_key_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_issue (mem_re),
    .rd_data  (mem_rdata),
    .scfg     (scfg),
    .res      (res)
  );

  brt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .dim0      (dim0_r),
    .dim1      (dim1_r),
    .dim2      (dim2_r),
    .dim3      (dim3_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .scfg      (scfg),
    .res       (res)
  );

endmodule

// ----- rtl/brt_entry_mem.sv -----
// Entry store: one write port and one registered read port.
// Depends on brt_pkg for the entry width.
module brt_entry_mem #(
  parameter int TABLE_DEPTH = brt_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [brt_pkg::ENTRY_W-1:0] wdata,
  input  logic                        re,
  input  logic [IDX_W-1:0]            raddr,
  output logic [brt_pkg::ENTRY_W-1:0] rdata
);

  logic [brt_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/brt_key_pipe.sv -----
// Key pipeline: stride products, key sum and range check for each entry read.
// Depends on brt_pkg for scan_cfg_t and scan_res_t.
module brt_key_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_issue,
  input  logic [brt_pkg::ENTRY_W-1:0] rd_data,
  input  brt_pkg::scan_cfg_t          scfg,
  output brt_pkg::scan_res_t          res
);

  logic [15:0] c0, c1, c2, c3;
  logic [31:0] p1_c;
  logic [31:0] p2_full, p3_full;
  logic        bad_c;

  logic        v0_r, v1_r, v2_r;
  logic [31:0] p1_r, p2_r, p3_r;
  logic [15:0] c0_r;
  logic        bad1_r, bad2_r;
  logic [brt_pkg::ENTRY_W-1:0] e1_r, e2_r;
  logic [brt_pkg::KEY_W-1:0]   key2_r;

  assign c0 = rd_data[15:0];
  assign c1 = rd_data[31:16];
  assign c2 = rd_data[47:32];
  assign c3 = rd_data[63:48];

  // Stride products, each truncated to the key width
  assign p1_c    = {16'b0, c1} * {16'b0, scfg.dim0};
  assign p2_full = {16'b0, c2} * scfg.m2;
  assign p3_full = {16'b0, c3} * scfg.m3;

  // Any coordinate at or past its dimension marks the entry bad
  assign bad_c = (c0 >= scfg.dim0) | (c1 >= scfg.dim1) |
                 (c2 >= scfg.dim2) | (c3 >= scfg.dim3);

  // Valid bits track read data through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= rd_issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Stage one: register products
  always_ff @(posedge clk) begin
    if (v0_r) begin
      p1_r   <= p1_c;
      p2_r   <= p2_full;
      p3_r   <= p3_full;
      c0_r   <= c0;
      bad1_r <= bad_c;
      e1_r   <= rd_data;
    end
  end

  // Stage two: register the wrapped key sum
  always_ff @(posedge clk) begin
    if (v1_r) begin
      key2_r <= {16'b0, c0_r} + p1_r + p2_r + p3_r;
      bad2_r <= bad1_r;
      e2_r   <= e1_r;
    end
  end

  assign res.valid = v2_r;
  assign res.match = (key2_r == scfg.key);
  assign res.bad   = bad2_r;
  assign res.entry = e2_r;

endmodule

// ----- rtl/brt_ctrl.sv -----
// Command sequencer: count, scan pointers, compaction writes and result register.
// Depends on brt_pkg, brt_if and the assertion macro header.
`include "brick_request_table_core_macros.svh"
module brt_ctrl #(
  parameter int TABLE_DEPTH = brt_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  brt_in_if.sink                      in_chan,
  brt_out_if.source                   out_chan,
  input  logic [brt_pkg::DIM_W-1:0]   dim0,
  input  logic [brt_pkg::DIM_W-1:0]   dim1,
  input  logic [brt_pkg::DIM_W-1:0]   dim2,
  input  logic [brt_pkg::DIM_W-1:0]   dim3,
  output logic                        mem_we,
  output logic [IDX_W-1:0]            mem_waddr,
  output logic [brt_pkg::ENTRY_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [IDX_W-1:0]            mem_raddr,
  output brt_pkg::scan_cfg_t          scfg,
  input  brt_pkg::scan_res_t          res
);

  brt_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] ret_ptr_r, ret_ptr_nxt;
  logic [CNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  brt_pkg::cmd_t    cmd_r, cmd_nxt;
  brt_pkg::status_t status_r, status_nxt;
  logic             hit_r, hit_nxt;
  logic [brt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [brt_pkg::KEY_W-1:0] m2_r, m2_nxt;
  logic [brt_pkg::KEY_W-1:0] m3_r, m3_nxt;
  logic [brt_pkg::KEY_W-1:0] m3_full;

  logic             out_valid_r, out_valid_nxt;
  brt_pkg::status_t out_status_r, out_status_nxt;
  logic [brt_pkg::OUT_W-1:0] out_total_r, out_total_nxt;
  logic [brt_pkg::OUT_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_free;

  assign m3_full  = m2_r * {16'b0, dim2};
  assign out_free = !out_valid_r || out_chan.ready;

  assign scfg.dim0 = dim0;
  assign scfg.dim1 = dim1;
  assign scfg.dim2 = dim2;
  assign scfg.dim3 = dim3;
  assign scfg.m2   = m2_r;
  assign scfg.m3   = m3_r;
  assign scfg.key  = key_r;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_total = out_total_r;
  assign out_chan.position    = out_pos_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    ret_ptr_r    <= ret_ptr_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    pos_r        <= pos_nxt;
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    hit_r        <= hit_nxt;
    key_r        <= key_nxt;
    m2_r         <= m2_nxt;
    m3_r         <= m3_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_ptr_nxt     = rd_ptr_r;
    ret_ptr_nxt    = ret_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    pos_nxt        = pos_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    hit_nxt        = hit_r;
    key_nxt        = key_r;
    m2_nxt         = m2_r;
    m3_nxt         = m3_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    out_pos_nxt    = out_pos_r;
    in_chan.ready  = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[IDX_W-1:0];
    mem_wdata      = {in_chan.coord_3, in_chan.coord_2, in_chan.coord_1, in_chan.coord_0};
    mem_re         = 1'b0;
    mem_raddr      = rd_ptr_r[IDX_W-1:0];

    unique case (state_r)
      brt_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          cmd_nxt    = in_chan.command;
          key_nxt    = in_chan.search_key;
          status_nxt = brt_pkg::ST_OK;
          pos_nxt    = cnt_r;
          state_nxt  = brt_pkg::S_FINISH;
          case (in_chan.command) inside
            brt_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
              pos_nxt = '0;
            end
            brt_pkg::CMD_APPEND: begin
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                status_nxt = brt_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
                pos_nxt = cnt_r + CNT_W'(1);
              end
            end
            brt_pkg::CMD_FIND, brt_pkg::CMD_REMOVE, brt_pkg::CMD_VERIFY: begin
              rd_ptr_nxt  = '0;
              ret_ptr_nxt = '0;
              wr_ptr_nxt  = '0;
              hit_nxt     = 1'b0;
              state_nxt   = brt_pkg::S_MUL1;
            end
            default: begin
              // unused codes leave the table alone
            end
          endcase
        end
      end

      brt_pkg::S_MUL1: begin
        m2_nxt    = {16'b0, dim0} * {16'b0, dim1};
        state_nxt = brt_pkg::S_MUL2;
      end

      brt_pkg::S_MUL2: begin
        m3_nxt    = m3_full;
        state_nxt = brt_pkg::S_SCAN;
      end

      brt_pkg::S_SCAN: begin
        // Issue one read a cycle
        if (rd_ptr_r != cnt_r) begin
          mem_re     = 1'b1;
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
        // Retire entries in table order
        if (res.valid) begin
          ret_ptr_nxt = ret_ptr_r + CNT_W'(1);
          case (cmd_r)
            brt_pkg::CMD_FIND: begin
              if (res.match) begin
                hit_nxt = 1'b1;
                pos_nxt = ret_ptr_r;
              end
            end
            brt_pkg::CMD_REMOVE: begin
              if (res.match) begin
                hit_nxt = 1'b1;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = wr_ptr_r[IDX_W-1:0];
                mem_wdata  = res.entry;
                wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
              end
            end
            default: begin
              // verify keeps the first bad entry only
              if (res.bad && !hit_r) begin
                hit_nxt    = 1'b1;
                pos_nxt    = ret_ptr_r;
                status_nxt = brt_pkg::ST_BAD;
              end
            end
          endcase
        end
        // All entries retired: settle the result
        if (ret_ptr_r == cnt_r) begin
          state_nxt = brt_pkg::S_FINISH;
          case (cmd_r)
            brt_pkg::CMD_FIND: begin
              status_nxt = hit_r ? brt_pkg::ST_OK : brt_pkg::ST_MISSING;
            end
            brt_pkg::CMD_REMOVE: begin
              status_nxt = hit_r ? brt_pkg::ST_OK : brt_pkg::ST_MISSING;
              cnt_nxt    = wr_ptr_r;
              pos_nxt    = wr_ptr_r;
            end
            default: begin
            end
          endcase
        end
      end

      brt_pkg::S_FINISH: begin
        // Hold until the result register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_total_nxt  = brt_pkg::OUT_W'(cnt_r);
          out_pos_nxt    = brt_pkg::OUT_W'(pos_r);
          state_nxt      = brt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = brt_pkg::S_IDLE;
      end
    endcase
  end

  `BRT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  `BRT_ASSERT_NOW(a_compact_behind, state_r == brt_pkg::S_SCAN,
                  (wr_ptr_r <= ret_ptr_r) && (ret_ptr_r <= rd_ptr_r),
                  "scan pointers out of order")
  `BRT_ASSERT_NOW(a_retire_in_scan, res.valid, state_r == brt_pkg::S_SCAN,
                  "entry retired outside a scan")
  `BRT_ASSERT_NEXT(a_finish_loads, (state_r == brt_pkg::S_FINISH) && out_free,
                   out_valid_r && (state_r == brt_pkg::S_IDLE),
                   "result not loaded on finish")

endmodule
